// ===== hw/rtl/streaming_tail_var_es_assert.svh =====
// assertion macros shared by the tail tracker modules
`ifndef STREAMING_TAIL_VAR_ES_ASSERT_SVH
`define STREAMING_TAIL_VAR_ES_ASSERT_SVH
`ifndef SYNTHESIS
`define STVE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("stve assertion failed");
`define STVE_ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("stve assertion failed");
`else
`define STVE_ASSERT(lbl, clk, rst, prop)
`define STVE_ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

// ===== hw/rtl/stve_pkg.sv =====
// types and constants of the streaming tail tracker
package stve_pkg;

   localparam int TAIL_MAX    = 256;
   localparam int LOSS_W      = 32;
   localparam int TAIL_SIZE_W = 9;
   localparam int IDX_W       = (TAIL_MAX > 1) ? $clog2(TAIL_MAX) : 1;
   localparam int CNT_W       = $clog2(TAIL_MAX + 1);
   localparam int SUM_W       = LOSS_W + IDX_W;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS + 1);

   typedef enum logic {
      ENG_IDLE,
      ENG_SCAN
   } eng_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_OUT
   } div_state_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [LOSS_W-1:0] var_value;
      logic signed [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]         count;
   } job_type;

endpackage

// ===== hw/rtl/stve_queue.sv =====
// two-beat input queue between the request port and the tracker engine
module stve_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [stve_pkg::LOSS_W-1:0] req_loss,
   output logic                              q_valid,
   output logic signed [stve_pkg::LOSS_W-1:0] q_loss,
   input  logic                              q_take
);

   logic signed [stve_pkg::LOSS_W-1:0] slots_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_loss    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= req_loss;
      end
   end

endmodule

// ===== hw/rtl/stve_engine.sv =====
// tracker engine: tail store, count, sum, smallest entry and rescan
`include "streaming_tail_var_es_assert.svh"
module stve_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [stve_pkg::TAIL_SIZE_W-1:0]       csr_wr_data,
   input  logic                                   q_valid,
   input  logic signed [stve_pkg::LOSS_W-1:0]     q_loss,
   output logic                                   q_take,
   output logic                                   job_valid,
   output stve_pkg::job_type                      job,
   input  logic                                   job_ready
);

   logic [stve_pkg::TAIL_SIZE_W-1:0]   tail_size_ff;
   logic [stve_pkg::CNT_W-1:0]         eff_k;

   stve_pkg::eng_state_type            state_ff;
   stve_pkg::eng_state_type            state_in;
   logic [stve_pkg::CNT_W-1:0]         count_ff;
   logic [stve_pkg::CNT_W-1:0]         count_in;
   logic signed [stve_pkg::SUM_W-1:0]  sum_ff;
   logic signed [stve_pkg::SUM_W-1:0]  sum_in;
   logic signed [stve_pkg::LOSS_W-1:0] min_ff;
   logic signed [stve_pkg::LOSS_W-1:0] min_in;
   logic [stve_pkg::IDX_W-1:0]         min_slot_ff;
   logic [stve_pkg::IDX_W-1:0]         min_slot_in;
   logic [stve_pkg::CNT_W-1:0]         issue_ff;
   logic [stve_pkg::CNT_W-1:0]         issue_in;
   logic                               rd_valid_ff;
   logic                               rd_valid_in;
   logic [stve_pkg::IDX_W-1:0]         rd_slot_ff;
   logic [stve_pkg::IDX_W-1:0]         rd_slot_in;
   logic signed [stve_pkg::LOSS_W-1:0] rd_data_ff;
   logic                               job_valid_ff;
   logic                               job_valid_in;
   stve_pkg::job_type                  job_ff;
   stve_pkg::job_type                  job_in;
   logic                               wr_en;
   logic [stve_pkg::IDX_W-1:0]         wr_addr;
   logic [stve_pkg::IDX_W-1:0]         last_slot;

   logic signed [stve_pkg::LOSS_W-1:0] store_ff [stve_pkg::TAIL_MAX];

   // zero reads as one, large values saturate
   always_comb begin
      if (tail_size_ff == '0) begin
         eff_k = stve_pkg::CNT_W'(1);
      end else if (32'(tail_size_ff) > 32'(stve_pkg::TAIL_MAX)) begin
         eff_k = stve_pkg::CNT_W'(stve_pkg::TAIL_MAX);
      end else begin
         eff_k = stve_pkg::CNT_W'(tail_size_ff);
      end
   end

   assign last_slot = stve_pkg::IDX_W'(count_ff - 1'b1);
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      min_slot_in  = min_slot_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_slot_in   = issue_ff[stve_pkg::IDX_W-1:0];
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[stve_pkg::IDX_W-1:0];
      q_take       = 1'b0;
      if (job_valid_ff && job_ready) begin
         job_valid_in = 1'b0;
      end
      case (state_ff)
         stve_pkg::ENG_IDLE: begin
            if (q_valid && !job_valid_ff) begin
               q_take = 1'b1;
               if (count_ff < eff_k) begin
                  // still filling
                  wr_en    = 1'b1;
                  count_in = stve_pkg::CNT_W'(count_ff + 1'b1);
                  sum_in   = sum_ff + stve_pkg::SUM_W'(q_loss);
                  if (count_ff == '0 || q_loss < min_ff) begin
                     min_in      = q_loss;
                     min_slot_in = count_ff[stve_pkg::IDX_W-1:0];
                  end
                  job_valid_in       = 1'b1;
                  job_in.accepted    = 1'b1;
                  job_in.var_value   = min_in;
                  job_in.sum         = sum_in;
                  job_in.count       = count_in;
               end else if (q_loss > min_ff) begin
                  // replace smallest, then rescan for the new smallest
                  wr_en    = 1'b1;
                  wr_addr  = min_slot_ff;
                  sum_in   = sum_ff - stve_pkg::SUM_W'(min_ff) + stve_pkg::SUM_W'(q_loss);
                  issue_in = '0;
                  state_in = stve_pkg::ENG_SCAN;
               end else begin
                  job_valid_in       = 1'b1;
                  job_in.accepted    = 1'b0;
                  job_in.var_value   = min_ff;
                  job_in.sum         = sum_ff;
                  job_in.count       = count_ff;
               end
            end
         end
         stve_pkg::ENG_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_valid_in = 1'b1;
               issue_in    = stve_pkg::CNT_W'(issue_ff + 1'b1);
            end
            if (rd_valid_ff) begin
               if (rd_slot_ff == '0 || rd_data_ff < min_ff) begin
                  min_in      = rd_data_ff;
                  min_slot_in = rd_slot_ff;
               end
               if (rd_slot_ff == last_slot) begin
                  state_in           = stve_pkg::ENG_IDLE;
                  job_valid_in       = 1'b1;
                  job_in.accepted    = 1'b1;
                  job_in.var_value   = min_in;
                  job_in.sum         = sum_ff;
                  job_in.count       = count_ff;
               end
            end
         end
         default: begin
            state_in = stve_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_size_ff <= stve_pkg::TAIL_SIZE_W'(1);
         state_ff     <= stve_pkg::ENG_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tail_size_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rd_valid_ff  <= rd_valid_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      min_slot_ff <= min_slot_in;
      issue_ff    <= issue_in;
      rd_slot_ff  <= rd_slot_in;
      job_ff      <= job_in;
   end

   // tail store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= q_loss;
      end
      rd_data_ff <= store_ff[issue_ff[stve_pkg::IDX_W-1:0]];
   end

   `STVE_ASSERT_NEVER(a_scan_no_job, clock, reset, state_ff == stve_pkg::ENG_SCAN && job_valid_ff)
   `STVE_ASSERT_NEVER(a_count_max, clock, reset, count_ff > stve_pkg::CNT_W'(stve_pkg::TAIL_MAX))
   `STVE_ASSERT(a_job_count, clock, reset, job_valid_ff |-> job_ff.count != '0)

endmodule

// ===== hw/rtl/stve_divider.sv =====
// mean of the held losses by restoring division, plus the result register
`include "streaming_tail_var_es_assert.svh"
module stve_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_valid,
   input  stve_pkg::job_type                      job,
   output logic                                   job_ready,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic signed [stve_pkg::LOSS_W-1:0]     rsp_var_value,
   output logic signed [stve_pkg::LOSS_W-1:0]     rsp_es_value,
   output logic [stve_pkg::TAIL_SIZE_W-1:0]       rsp_retained_count
);

   stve_pkg::div_state_type            state_ff;
   stve_pkg::div_state_type            state_in;
   logic [stve_pkg::STEP_W-1:0]        step_ff;
   logic [stve_pkg::STEP_W-1:0]        step_in;
   logic [stve_pkg::SUM_W-1:0]         quo_ff;
   logic [stve_pkg::SUM_W-1:0]         quo_in;
   logic [stve_pkg::CNT_W-1:0]         rem_ff;
   logic [stve_pkg::CNT_W-1:0]         rem_in;
   logic [stve_pkg::CNT_W-1:0]         div_ff;
   logic [stve_pkg::CNT_W-1:0]         div_in;
   logic                               neg_ff;
   logic                               neg_in;
   logic                               acc_ff;
   logic                               acc_in;
   logic signed [stve_pkg::LOSS_W-1:0] var_ff;
   logic signed [stve_pkg::LOSS_W-1:0] var_in;
   logic [stve_pkg::CNT_W:0]           trial;
   logic                               fits;
   logic [stve_pkg::LOSS_W-1:0]        es_mag;
   logic                               load;

   assign trial  = {rem_ff, quo_ff[stve_pkg::SUM_W-1]};
   assign fits   = (trial >= {1'b0, div_ff});
   assign es_mag = quo_ff[stve_pkg::LOSS_W-1:0];

   assign rsp_valid          = (state_ff == stve_pkg::DIV_OUT);
   assign rsp_accepted       = acc_ff;
   assign rsp_var_value      = var_ff;
   assign rsp_es_value       = neg_ff ? -es_mag : es_mag;
   assign rsp_retained_count = stve_pkg::TAIL_SIZE_W'(div_ff);

   always_comb begin
      job_ready = (state_ff == stve_pkg::DIV_IDLE) ||
                  (state_ff == stve_pkg::DIV_OUT && !rsp_stall);
      load      = job_valid && job_ready;
      state_in  = state_ff;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      var_in    = var_ff;
      case (state_ff)
         stve_pkg::DIV_IDLE: begin
         end
         stve_pkg::DIV_RUN: begin
            quo_in  = {quo_ff[stve_pkg::SUM_W-2:0], fits};
            rem_in  = fits ? stve_pkg::CNT_W'(trial - {1'b0, div_ff})
                           : stve_pkg::CNT_W'(trial);
            step_in = stve_pkg::STEP_W'(step_ff + 1'b1);
            if (step_ff == stve_pkg::STEP_W'(stve_pkg::DIV_STEPS - 1)) begin
               state_in = stve_pkg::DIV_OUT;
            end
         end
         stve_pkg::DIV_OUT: begin
            if (!rsp_stall) begin
               state_in = stve_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = stve_pkg::DIV_IDLE;
         end
      endcase
      if (load) begin
         state_in = stve_pkg::DIV_RUN;
         step_in  = '0;
         rem_in   = '0;
         neg_in   = job.sum[stve_pkg::SUM_W-1];
         quo_in   = job.sum[stve_pkg::SUM_W-1] ? -job.sum : job.sum;
         div_in   = job.count;
         acc_in   = job.accepted;
         var_in   = job.var_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stve_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      var_ff  <= var_in;
   end

   `STVE_ASSERT(a_div_nonzero, clock, reset, state_ff != stve_pkg::DIV_IDLE |-> div_ff != '0)
   `STVE_ASSERT_NEVER(a_rem_range, clock, reset, state_ff != stve_pkg::DIV_IDLE && rem_ff >= div_ff)

endmodule

// ===== hw/rtl/streaming_tail_var_es.sv =====
// top level of the streaming largest-loss tracker
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_loss
//   rsp      out        rsp_valid/rsp_stall  rsp_accepted, rsp_var_value,
//                                            rsp_es_value, rsp_retained_count
//   csr      in         csr_wr_en            csr_wr_data (tail size)
//
// a kept-while-filling or rejected beat is finished in the idle state of the engine, a
// replacement then rescans the tail store for the new smallest
// the mean comes from the shared restoring divider (one quotient bit per
// cycle over the 40-bit sum), overlapped with the engine working on the next beat
// synchronous reset clears count and sum and sets tail size to 1; the store needs no clearing
// two beats queue at the input while the engine or the result register is stalled
module streaming_tail_var_es (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [stve_pkg::LOSS_W-1:0]     req_loss,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic signed [stve_pkg::LOSS_W-1:0]     rsp_var_value,
   output logic signed [stve_pkg::LOSS_W-1:0]     rsp_es_value,
   output logic [stve_pkg::TAIL_SIZE_W-1:0]       rsp_retained_count,
   input  logic                                   csr_wr_en,
   input  logic [stve_pkg::TAIL_SIZE_W-1:0]       csr_wr_data
);

   logic                               q_valid;
   logic signed [stve_pkg::LOSS_W-1:0] q_loss;
   logic                               q_take;
   logic                               job_valid;
   logic                               job_ready;
   stve_pkg::job_type                  job;

   stve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_loss  (req_loss),
      .q_valid   (q_valid),
      .q_loss    (q_loss),
      .q_take    (q_take)
   );

   stve_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_loss      (q_loss),
      .q_take      (q_take),
      .job_valid   (job_valid),
      .job         (job),
      .job_ready   (job_ready)
   );

   stve_divider u_divider (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (job),
      .job_ready          (job_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_var_value      (rsp_var_value),
      .rsp_es_value       (rsp_es_value),
      .rsp_retained_count (rsp_retained_count)
   );

endmodule
